// ----- hdl/wsu_pkg.sv -----
// Shared constants, types and helpers for the wavelet synthesis upconverter.
// No dependencies; imported by every module of the block.
`default_nettype none
package wsu_pkg;

  localparam int MAX_TAPS   = 16;
  localparam int NUM_CELLS  = MAX_TAPS / 2;
  localparam int CELL_IDX_W = $clog2(NUM_CELLS);
  localparam int NUM_PROD   = 2 * NUM_CELLS;
  localparam int TREE_LVLS  = $clog2(NUM_PROD);

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int COEF_IDX_W = 4;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + TREE_LVLS;
  localparam int QUO_W      = ACC_W - FRAC_W;

  localparam int CMD_W      = 2;
  localparam int TAP_CNT_W  = 5;
  localparam int CROP_W     = 7;
  localparam int LEN_W      = 16;
  localparam int IDX_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PAIR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd2;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST     = 5'd8;
  localparam logic [CROP_W-1:0]    CROP_COUNT_RST    = 7'd7;
  localparam logic [LEN_W-1:0]     OUTPUT_LENGTH_RST = 16'd64;
  localparam logic [IDX_W-1:0]     IDX_MAX           = '1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef prod_t [NUM_PROD-1:0]       prod_vec_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = -16'sh8000;

  typedef struct packed {
    logic shift;
    logic clear;
    logic prod_en;
    logic phase;
    logic tap_on;
    logic we_lo;
    logic we_hi;
    logic we_odd;
  } cell_ctl_t;

  // Round half up at the binary point, then clamp to the sample range.
  function automatic sample_t round_sat(input acc_t acc);
    acc_t                     t;
    logic signed [QUO_W-1:0]  q;
    logic signed [QUO_W-1:0]  hi;
    logic signed [QUO_W-1:0]  lo;
    sample_t                  r;
    t  = acc + $signed({{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
    q  = t[ACC_W-1:FRAC_W];
    hi = QUO_W'(SAMPLE_MAX);
    lo = QUO_W'(SAMPLE_MIN);
    if (q > hi) r = SAMPLE_MAX;
    else if (q < lo) r = SAMPLE_MIN;
    else r = q[SAMPLE_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/wsu_cell.sv -----
// One synthesis cell: a history pair, two low and two high taps, two multipliers.
// Depends on wsu_pkg.
`default_nettype none
module wsu_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  wsu_pkg::cell_ctl_t ctl,
  input  wsu_pkg::coef_t     coef_value,
  input  wsu_pkg::sample_t   feed_a,
  input  wsu_pkg::sample_t   feed_d,
  output wsu_pkg::sample_t   hist_a,
  output wsu_pkg::sample_t   hist_d,
  output wsu_pkg::prod_t     prod_a,
  output wsu_pkg::prod_t     prod_d
);
  import wsu_pkg::*;

  sample_t a_r;
  sample_t d_r;
  coef_t   lo_r [2];
  coef_t   hi_r [2];
  prod_t   prod_a_r;
  prod_t   prod_d_r;
  prod_t   ax;
  prod_t   dx;
  prod_t   lx;
  prod_t   hx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      d_r <= '0;
    end else if (ctl.shift) begin
      a_r <= feed_a;
      d_r <= feed_d;
    end else if (ctl.clear) begin
      a_r <= '0;
      d_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we_lo) lo_r[ctl.we_odd] <= coef_value;
    if (ctl.we_hi) hi_r[ctl.we_odd] <= coef_value;
  end

  assign ax = PROD_W'(a_r);
  assign dx = PROD_W'(d_r);
  assign lx = PROD_W'(lo_r[ctl.phase]);
  assign hx = PROD_W'(hi_r[ctl.phase]);

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_a_r <= ctl.tap_on ? ax * lx : '0;
      prod_d_r <= ctl.tap_on ? dx * hx : '0;
    end
  end

  assign hist_a = a_r;
  assign hist_d = d_r;
  assign prod_a = prod_a_r;
  assign prod_d = prod_d_r;

endmodule
`default_nettype wire

// ----- hdl/wsu_sum_tree.sv -----
// Registered adder tree over the cell products, then round, clamp and output register.
// Depends on wsu_pkg.
`default_nettype none
module wsu_sum_tree (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  wsu_pkg::prod_vec_t  prods,
  output logic                out_valid,
  input  logic                out_ready,
  output wsu_pkg::sample_t    out_recon_sample,
  output logic                out_run_last
);
  import wsu_pkg::*;

  acc_t                   node_r   [NUM_PROD-1];
  acc_t                   node_nxt [NUM_PROD-1];
  logic [NUM_PROD-2:0]    node_en;
  logic [TREE_LVLS-1:0]   v_r;
  logic [TREE_LVLS-1:0]   last_r;
  logic [TREE_LVLS:0]     rdy;
  logic                   out_valid_r;
  logic                   out_last_r;
  sample_t                out_data_r;

  always_comb begin
    rdy[TREE_LVLS] = !out_valid_r || out_ready;
    for (int s = TREE_LVLS - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  for (genvar n = 0; n < NUM_PROD - 1; n++) begin : g_node
    localparam int D = $clog2(n + 2) - 1;
    localparam int S = TREE_LVLS - 1 - D;
    acc_t lhs;
    acc_t rhs;
    if (2 * n + 1 >= NUM_PROD - 1) begin : g_leaf
      assign lhs = ACC_W'($signed(prods[2*n+1-(NUM_PROD-1)]));
      assign rhs = ACC_W'($signed(prods[2*n+2-(NUM_PROD-1)]));
    end else begin : g_inner
      assign lhs = node_r[2*n+1];
      assign rhs = node_r[2*n+2];
    end
    assign node_nxt[n] = lhs + rhs;
    assign node_en[n]  = rdy[S];
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < NUM_PROD - 1; n++) begin
      if (node_en[n]) node_r[n] <= node_nxt[n];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int s = 1; s < TREE_LVLS; s++) begin
        if (rdy[s]) v_r[s] <= v_r[s-1];
      end
      if (rdy[TREE_LVLS]) out_valid_r <= v_r[TREE_LVLS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) last_r[0] <= in_last;
    for (int s = 1; s < TREE_LVLS; s++) begin
      if (rdy[s]) last_r[s] <= last_r[s-1];
    end
    if (rdy[TREE_LVLS]) begin
      out_last_r <= last_r[TREE_LVLS-1];
      out_data_r <= round_sat(node_r[0]);
    end
  end

  assign in_ready         = rdy[0];
  assign out_valid        = out_valid_r;
  assign out_recon_sample = out_data_r;
  assign out_run_last     = out_last_r;

endmodule
`default_nettype wire

// ----- hdl/wavelet_synthesis_upconv.sv -----
// Top level: two-band inverse wavelet synthesis, one level, chain of synthesis cells.
// Depends on wsu_pkg, wsu_cell and wsu_sum_tree.
//
//   channel | dir | handshake            | payload
//   in      | in  | in_valid / in_ready  | command, coef_bank/index/value, approx/detail
//   out     | out | out_valid / out_ready| recon_sample, run_last
//   cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// A pair or flush item holds the cell row for a PH0 slot and, unless its run ends there,
// a PH1 slot, in which the next pair is taken if the product stage is ready. Coefficient
// loads write on acceptance. Slot products pass the tree levels and the output register.
// Reset clears histories, run counters, pipeline valids and the registers to their
// defaults; coefficients are undefined until loaded. Backpressure on out stalls
// each pipeline stage only when the stage after it is full.
`default_nettype none
module wavelet_synthesis_upconv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wsu_pkg::CMD_W-1:0]         in_command,
  input  logic                              in_coef_bank,
  input  logic [wsu_pkg::COEF_IDX_W-1:0]    in_coef_index,
  input  wsu_pkg::coef_t                    in_coef_value,
  input  wsu_pkg::sample_t                  in_approx_sample,
  input  wsu_pkg::sample_t                  in_detail_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wsu_pkg::sample_t                  out_recon_sample,
  output logic                              out_run_last,
  input  logic                              cfg_we,
  input  logic [wsu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wsu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PH0  = 2'd1;
  localparam logic [1:0] ST_PH1  = 2'd2;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [TAP_CNT_W-1:0] tap_count_r;
  logic [CROP_W-1:0]    crop_count_r;
  logic [LEN_W-1:0]     output_length_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic [LEN_W-1:0]     emitted_r;
  logic [LEN_W-1:0]     emitted_nxt;
  logic                 v_p_r;
  logic                 last_p_r;
  logic                 rdy_p;
  logic                 tree_ready;
  logic                 in_fire;
  logic                 is_pair;
  logic                 is_load;
  logic                 slot;
  logic                 phase;
  logic [IDX_W-1:0]     k;
  logic                 emit;
  logic                 slot_last;
  logic                 clear;
  logic                 shift;
  sample_t              hist_a [NUM_CELLS];
  sample_t              hist_d [NUM_CELLS];
  sample_t              feed_a [NUM_CELLS];
  sample_t              feed_d [NUM_CELLS];
  cell_ctl_t            ctl    [NUM_CELLS];
  prod_vec_t            prods;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r     <= TAP_COUNT_RST;
      crop_count_r    <= CROP_COUNT_RST;
      output_length_r <= OUTPUT_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAP_COUNT:     tap_count_r     <= cfg_data[TAP_CNT_W-1:0];
        CFG_CROP_COUNT:    crop_count_r    <= cfg_data[CROP_W-1:0];
        CFG_OUTPUT_LENGTH: output_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign rdy_p    = !v_p_r || tree_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_PH1) && rdy_p);
  assign in_fire  = in_valid && in_ready;
  assign is_pair  = (in_command == CMD_PAIR) || (in_command == CMD_FLUSH);
  assign is_load  = in_command == CMD_LOAD;
  assign shift    = in_fire && is_pair;

  assign slot      = ((state_r == ST_PH0) || (state_r == ST_PH1)) && rdy_p;
  assign phase     = state_r == ST_PH1;
  assign k         = (idx_r == IDX_MAX) ? idx_r : idx_r + IDX_W'(1);
  assign emit      = (k >= IDX_W'(crop_count_r)) && (emitted_r < output_length_r);
  assign slot_last = emit && ((emitted_r + LEN_W'(1)) == output_length_r);
  assign clear     = slot && slot_last;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    emitted_nxt = emitted_r;
    if (slot) begin
      if (slot_last) begin
        idx_nxt     = '0;
        emitted_nxt = '0;
      end else begin
        idx_nxt     = k;
        emitted_nxt = emit ? emitted_r + LEN_W'(1) : emitted_r;
      end
    end
    case (state_r)
      ST_IDLE: if (shift) state_nxt = ST_PH0;
      ST_PH0:  if (rdy_p) state_nxt = slot_last ? ST_IDLE : ST_PH1;
      ST_PH1:  if (rdy_p) state_nxt = shift ? ST_PH0 : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      emitted_r <= '0;
      v_p_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      emitted_r <= emitted_nxt;
      if (rdy_p) v_p_r <= slot && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p) last_p_r <= slot_last;
  end

  for (genvar m = 0; m < NUM_CELLS; m++) begin : g_cell
    if (m == 0) begin : g_head
      assign feed_a[m] = (in_command == CMD_PAIR) ? in_approx_sample : '0;
      assign feed_d[m] = (in_command == CMD_PAIR) ? in_detail_sample : '0;
    end else begin : g_body
      assign feed_a[m] = clear ? '0 : hist_a[m-1];
      assign feed_d[m] = clear ? '0 : hist_d[m-1];
    end

    always_comb begin
      ctl[m].shift   = shift;
      ctl[m].clear   = clear;
      ctl[m].prod_en = rdy_p;
      ctl[m].phase   = phase;
      ctl[m].tap_on  = TAP_CNT_W'({CELL_IDX_W'(m), phase}) < tap_count_r;
      ctl[m].we_lo   = in_fire && is_load && !in_coef_bank
                       && (in_coef_index[COEF_IDX_W-1:1] == CELL_IDX_W'(m));
      ctl[m].we_hi   = in_fire && is_load && in_coef_bank
                       && (in_coef_index[COEF_IDX_W-1:1] == CELL_IDX_W'(m));
      ctl[m].we_odd  = in_coef_index[0];
    end

    wsu_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[m]),
      .coef_value (in_coef_value),
      .feed_a     (feed_a[m]),
      .feed_d     (feed_d[m]),
      .hist_a     (hist_a[m]),
      .hist_d     (hist_d[m]),
      .prod_a     (prods[2*m]),
      .prod_d     (prods[2*m+1])
    );
  end

  wsu_sum_tree u_sum_tree (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (v_p_r),
    .in_last          (last_p_r),
    .in_ready         (tree_ready),
    .prods            (prods),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_recon_sample (out_recon_sample),
    .out_run_last     (out_run_last)
  );

  // end of run resets the position and emitted counters
  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (idx_r == '0) && (emitted_r == '0))
    else $error("run counters not cleared after last sample");

  // accepted pair always starts with the first output phase
  a_pair_starts_ph0: assert property (@(posedge clk) disable iff (!rst_n)
    shift |=> state_r == ST_PH0)
    else $error("pair transfer did not start phase 0");

  // first phase slot never overlaps an input transfer
  a_no_accept_in_ph0: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PH0 |-> !in_ready)
    else $error("input accepted during phase 0");

  // a slot with the last mark always leaves a valid product stage behind
  a_last_is_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    clear && rdy_p |=> v_p_r && last_p_r)
    else $error("last sample not entered into pipeline");

endmodule
`default_nettype wire
